>>> hdl/gmsc_pkg.sv
// Shared types, codes and helpers for the gate motor state controller.
package gmsc_pkg;

	// Default width of the guard and wicket pulse countdowns
	localparam int TIMER_WIDTH_DEF = 16;

	// Stream payload widths
	localparam int IN_DATA_W  = 16;
	localparam int IN_USER_W  = 4;
	localparam int OUT_DATA_W = 48;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_GUARD_TICKS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH  = 2'd2;
	localparam logic [CFG_DATA_W-1:0] PULSE_TICKS_RST = 16'd1000;

	typedef enum logic [3:0] {
		OP_TICK         = 4'd0,
		OP_OPEN         = 4'd1,
		OP_CLOSE        = 4'd2,
		OP_STOP         = 4'd3,
		OP_WICKET_PULSE = 4'd4,
		OP_SET_LIGHT    = 4'd5,
		OP_TOGGLE_LIGHT = 4'd6,
		OP_SET_WICKET   = 4'd7,
		OP_SENSORS      = 4'd8
	} op_t;

	typedef enum logic [2:0] {
		GATE_UNKNOWN = 3'd0,
		GATE_OPENING = 3'd1,
		GATE_CLOSING = 3'd2,
		GATE_STOPPED = 3'd3,
		GATE_OPEN    = 3'd4,
		GATE_CLOSED  = 3'd5
	} gate_t;

	// Motor drive; also used for the pending drive after the guard
	typedef enum logic [1:0] {
		MOTOR_STOP  = 2'd0,
		MOTOR_OPEN  = 2'd1,
		MOTOR_CLOSE = 2'd2
	} motor_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef struct packed {
		logic              active;
		logic              in_motion;
		logic signed [1:0] direction;
		logic              just_settled;
		logic signed [1:0] settled_direction;
	} sensor_t;

	typedef struct packed {
		op_t     op;
		logic    flag;
		sensor_t upper;
		sensor_t lower;
	} item_t;

	typedef struct packed {
		gate_t       gate_state;
		motor_t      motor_state;
		logic        open_relay_level;
		logic        close_relay_level;
		logic        wicket_relay_level;
		logic        light_relay_level;
		logic        light_is_on;
		logic        wicket_is_open;
		logic        wicket_pulsing;
		logic [31:0] revision;
	} result_t;

	// Two's complement sign: 1 up, -1 (or -2) down, 0 none
	function automatic dir_t dir_of(logic [1:0] v);
		dir_t d;
		unique case (v)
			2'b00:   d = DIR_NONE;
			2'b01:   d = DIR_UP;
			default: d = DIR_DOWN;
		endcase
		return d;
	endfunction

	// Pin level for a relay given its energized state and polarity
	function automatic logic relay_level(logic on, logic active_high);
		return ~(on ^ active_high);
	endfunction

endpackage

>>> hdl/gmsc_core.sv
// Gate, motor, timer and flag state with the per-item update logic.
module gmsc_core #(
	parameter int TIMER_WIDTH = gmsc_pkg::TIMER_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	input  gmsc_pkg::item_t                     item,
	input  logic [gmsc_pkg::CFG_DATA_W-1:0]     guard_ticks,
	input  logic [gmsc_pkg::CFG_DATA_W-1:0]     wicket_pulse_ticks,
	input  logic                                relay_active_high,
	output gmsc_pkg::result_t                   result
);
	import gmsc_pkg::*;

	localparam logic [TIMER_WIDTH-1:0] T_ONE = TIMER_WIDTH'(1);

	gate_t                  gate_q, gate_d;
	motor_t                 motor_q, motor_d;
	motor_t                 pend_q, pend_d;
	logic [TIMER_WIDTH-1:0] guard_left_q, guard_left_d;
	logic                   pulse_act_q, pulse_act_d;
	logic [TIMER_WIDTH-1:0] pulse_left_q, pulse_left_d;
	logic                   light_q, light_d;
	logic                   wicket_q, wicket_d;
	logic [31:0]            count_q, count_d;

	// Next state; inc counts every visible change, intermediate ones too
	always_comb begin
		logic [2:0] inc;
		gate_t      tgt;
		dir_t       u_dir, l_dir, u_sdir, l_sdir;
		logic       limit_hit;

		gate_d       = gate_q;
		motor_d      = motor_q;
		pend_d       = pend_q;
		guard_left_d = guard_left_q;
		pulse_act_d  = pulse_act_q;
		pulse_left_d = pulse_left_q;
		light_d      = light_q;
		wicket_d     = wicket_q;
		inc          = '0;
		tgt          = GATE_UNKNOWN;
		limit_hit    = 1'b0;
		u_dir        = dir_of(item.upper.direction);
		l_dir        = dir_of(item.lower.direction);
		u_sdir       = dir_of(item.upper.settled_direction);
		l_sdir       = dir_of(item.lower.settled_direction);

		unique case (item.op)
			OP_TICK: begin
				if (pulse_act_q) begin
					if (pulse_left_q <= T_ONE) begin
						pulse_act_d  = 1'b0;
						pulse_left_d = '0;
						inc          = inc + 3'd1;
					end else begin
						pulse_left_d = pulse_left_q - T_ONE;
					end
				end
				if (pend_q != MOTOR_STOP) begin
					if (guard_left_q <= T_ONE) begin
						// guard over: energize the pending direction
						tgt = (pend_q == MOTOR_OPEN) ? GATE_OPENING : GATE_CLOSING;
						motor_d = pend_q;
						if (gate_d != tgt) inc = inc + 3'd1;
						gate_d       = tgt;
						pend_d       = MOTOR_STOP;
						guard_left_d = '0;
					end else begin
						guard_left_d = guard_left_q - T_ONE;
					end
				end
			end
			OP_OPEN, OP_CLOSE: begin
				motor_d      = MOTOR_STOP;
				pend_d       = (item.op == OP_OPEN) ? MOTOR_OPEN : MOTOR_CLOSE;
				guard_left_d = TIMER_WIDTH'(guard_ticks);
				if (guard_left_d == '0) begin
					tgt = (item.op == OP_OPEN) ? GATE_OPENING : GATE_CLOSING;
					motor_d = pend_d;
					if (gate_d != tgt) inc = inc + 3'd1;
					gate_d = tgt;
					pend_d = MOTOR_STOP;
				end
			end
			OP_STOP: begin
				motor_d      = MOTOR_STOP;
				pend_d       = MOTOR_STOP;
				guard_left_d = '0;
				if (gate_q != GATE_OPEN && gate_q != GATE_CLOSED &&
				    gate_q != GATE_STOPPED) begin
					gate_d = GATE_STOPPED;
					inc    = inc + 3'd1;
				end
			end
			OP_WICKET_PULSE: begin
				pulse_act_d  = 1'b1;
				pulse_left_d = TIMER_WIDTH'(wicket_pulse_ticks);
				inc          = inc + 3'd1;
			end
			OP_SET_LIGHT, OP_TOGGLE_LIGHT: begin
				light_d = (item.op == OP_SET_LIGHT) ? item.flag : ~light_q;
				if (light_d != light_q) inc = inc + 3'd1;
			end
			OP_SET_WICKET: begin
				wicket_d = item.flag;
				if (wicket_d != wicket_q) inc = inc + 3'd1;
			end
			OP_SENSORS: begin
				// upper motion, then lower motion
				if (item.upper.in_motion && item.upper.active && u_dir != DIR_NONE) begin
					tgt = (u_dir == DIR_UP) ? GATE_OPENING : GATE_CLOSING;
					if (gate_d != tgt) inc = inc + 3'd1;
					gate_d = tgt;
				end
				if (item.lower.in_motion && item.lower.active && l_dir != DIR_NONE) begin
					tgt = (l_dir == DIR_UP) ? GATE_OPENING : GATE_CLOSING;
					if (gate_d != tgt) inc = inc + 3'd1;
					gate_d = tgt;
				end
				// settling: limits stop the motor, otherwise follow the direction
				priority if (item.upper.just_settled && u_sdir == DIR_UP) begin
					tgt       = GATE_OPEN;
					limit_hit = 1'b1;
				end else if (item.lower.just_settled && l_sdir == DIR_DOWN) begin
					tgt       = GATE_CLOSED;
					limit_hit = 1'b1;
				end else if (item.upper.just_settled && u_sdir == DIR_DOWN) begin
					tgt = GATE_CLOSING;
				end else if (item.lower.just_settled && l_sdir == DIR_UP) begin
					tgt = GATE_OPENING;
				end else begin
					tgt = gate_d;
				end
				if (gate_d != tgt) inc = inc + 3'd1;
				gate_d = tgt;
				if (limit_hit) begin
					motor_d      = MOTOR_STOP;
					pend_d       = MOTOR_STOP;
					guard_left_d = '0;
				end else if (motor_d == MOTOR_STOP && gate_d == GATE_UNKNOWN) begin
					// idle with unknown position: infer from the single active sensor
					if (item.upper.active && !item.lower.active) begin
						gate_d = GATE_OPEN;
						inc    = inc + 3'd1;
					end else if (item.lower.active && !item.upper.active) begin
						gate_d = GATE_CLOSED;
						inc    = inc + 3'd1;
					end
				end
			end
			default: begin
			end
		endcase

		count_d = count_q + 32'(inc);
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q       <= GATE_UNKNOWN;
			motor_q      <= MOTOR_STOP;
			pend_q       <= MOTOR_STOP;
			guard_left_q <= '0;
			pulse_act_q  <= 1'b0;
			pulse_left_q <= '0;
			light_q      <= 1'b0;
			wicket_q     <= 1'b0;
			count_q      <= '0;
		end else if (item_valid) begin
			gate_q       <= gate_d;
			motor_q      <= motor_d;
			pend_q       <= pend_d;
			guard_left_q <= guard_left_d;
			pulse_act_q  <= pulse_act_d;
			pulse_left_q <= pulse_left_d;
			light_q      <= light_d;
			wicket_q     <= wicket_d;
			count_q      <= count_d;
		end
	end

	// Result shows the state after the item
	always_comb begin
		result.gate_state         = gate_d;
		result.motor_state        = motor_d;
		result.open_relay_level   = relay_level(motor_d == MOTOR_OPEN, relay_active_high);
		result.close_relay_level  = relay_level(motor_d == MOTOR_CLOSE, relay_active_high);
		result.wicket_relay_level = relay_level(pulse_act_d, relay_active_high);
		result.light_relay_level  = relay_level(light_d, relay_active_high);
		result.light_is_on        = light_d;
		result.wicket_is_open     = wicket_d;
		result.wicket_pulsing     = pulse_act_d;
		result.revision           = count_d;
	end

	// A pending drive keeps both motor relays off
	a_pend_motor_off: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != MOTOR_STOP |-> motor_q == MOTOR_STOP)
		else $error("motor driven while a drive is pending");

	// Guard counter is idle without a pending drive
	a_guard_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == MOTOR_STOP |-> guard_left_q == '0)
		else $error("guard running with no pending drive");

	// Pulse counter is idle without an active pulse
	a_pulse_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!pulse_act_q |-> pulse_left_q == '0)
		else $error("pulse counter running with no pulse");

endmodule

>>> hdl/gate_motor_state_controller.sv
// Top level of the gate motor state controller: stream ports, config and result queue.

// Takes one item per cycle (tick, open, close, stop, wicket pulse, light and wicket
// flags, sensor report) and returns one result item per input item showing the gate
// state, motor drive, relay pin levels, flags and the wrapping revision count after
// that item. Items pass an input register, then combinational update logic writes the
// result into a two-entry output queue; throughput is one item per cycle while the
// output is not stalled, and s_tready depends only on internal occupancy and stays high
// while one result waits downstream. Open and close drop both motor relays and arm a
// guard of guard_ticks ticks (zero energizes at once); the wicket pulse lasts
// wicket_pulse_ticks ticks. Countdowns are TIMER_WIDTH bits wide and the 16-bit
// registers are cut or zero-extended to that. Write configuration only while idle.
module gate_motor_state_controller #(
	parameter int TIMER_WIDTH = gmsc_pkg::TIMER_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// tdata, low bit up: flag, upper_active, upper_in_motion, upper_direction[1:0],
	// upper_just_settled, upper_settled_direction[1:0], lower_active,
	// lower_in_motion, lower_direction[1:0], lower_just_settled,
	// lower_settled_direction[1:0], one zero pad bit
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [gmsc_pkg::IN_DATA_W-1:0]      s_tdata,
	// tuser: op[3:0]
	input  logic [gmsc_pkg::IN_USER_W-1:0]      s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// tdata, low bit up: gate_state[2:0], motor_state[1:0], open_relay_level,
	// close_relay_level, wicket_relay_level, light_relay_level, light_is_on,
	// wicket_is_open, wicket_pulsing, revision[31:0], four zero pad bits
	output logic [gmsc_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gmsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gmsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import gmsc_pkg::*;

	logic [CFG_DATA_W-1:0] guard_ticks_q;
	logic [CFG_DATA_W-1:0] pulse_ticks_q;
	logic                  active_high_q;

	logic    in_accept;
	logic    valid_s1;
	item_t   item_s1;
	item_t   item_in;
	result_t core_result;
	result_t head;

	result_t    q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] q_count_q;
	logic [1:0] occupancy;
	logic       push;
	logic       pop;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_ticks_q <= '0;
			pulse_ticks_q <= PULSE_TICKS_RST;
			active_high_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_GUARD_TICKS: guard_ticks_q <= cfg_data;
				CFG_PULSE_TICKS: pulse_ticks_q <= cfg_data;
				CFG_ACTIVE_HIGH: active_high_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Unpack the input item
	always_comb begin
		item_in.op                      = op_t'(s_tuser);
		item_in.flag                    = s_tdata[0];
		item_in.upper.active            = s_tdata[1];
		item_in.upper.in_motion         = s_tdata[2];
		item_in.upper.direction         = s_tdata[4:3];
		item_in.upper.just_settled      = s_tdata[5];
		item_in.upper.settled_direction = s_tdata[7:6];
		item_in.lower.active            = s_tdata[8];
		item_in.lower.in_motion         = s_tdata[9];
		item_in.lower.direction         = s_tdata[11:10];
		item_in.lower.just_settled      = s_tdata[12];
		item_in.lower.settled_direction = s_tdata[14:13];
	end

	// Ready while the input register and queue together hold at most two items
	assign occupancy = q_count_q + {1'b0, valid_s1};
	assign s_tready  = (occupancy != 2'd3);
	assign in_accept = s_tvalid && s_tready;

	assign pop  = m_tvalid && m_tready;
	assign push = valid_s1 && ((q_count_q != 2'd2) || pop);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= item_in;
		end
	end

	gmsc_core #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_core (
		.clk                (clk),
		.arst_n             (arst_n),
		.item_valid         (push),
		.item               (item_s1),
		.guard_ticks        (guard_ticks_q),
		.wicket_pulse_ticks (pulse_ticks_q),
		.relay_active_high  (active_high_q),
		.result             (core_result)
	);

	// Two-entry result queue
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= core_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= 1'b0;
			rd_ptr_q  <= 1'b0;
			q_count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   q_count_q <= q_count_q + 2'd1;
				2'b01:   q_count_q <= q_count_q - 2'd1;
				default: q_count_q <= q_count_q;
			endcase
		end
	end

	assign m_tvalid = (q_count_q != 2'd0);
	assign head     = q_mem_q[rd_ptr_q];
	assign m_tdata  = {4'b0000, head.revision, head.wicket_pulsing, head.wicket_is_open,
		head.light_is_on, head.light_relay_level, head.wicket_relay_level,
		head.close_relay_level, head.open_relay_level, head.motor_state, head.gate_state};

	// Queue never overfills
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count_q != 2'd3)
		else $error("result queue count out of range");

	// Full queue with no pop holds the staged item
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && q_count_q == 2'd2 && !pop |=> valid_s1 && q_count_q == 2'd2)
		else $error("staged item lost while queue full");

	// An item accepted while the queue is empty passes the input register and is pushed into the queue
	a_push_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && q_count_q == 2'd0 |=> push)
		else $error("accepted item not pushed");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the gate motor state controller.
`timescale 1ns / 1ps

module testbench;
	import gmsc_pkg::*;

	// Opcodes past the last defined one: state report only
	localparam logic [3:0] OP_SPARE_LO = 4'd9;
	localparam logic [3:0] OP_SPARE_HI = 4'd15;
	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_ITEMS = 245;

	// Scoreboard: tracks controller state and holds the expected status items
	class gate_scoreboard;
		logic [15:0] guard_cfg;
		logic [15:0] pulse_cfg;
		bit          hi;
		gate_t       gate;
		motor_t      motor;
		motor_t      pend;
		logic [15:0] guard_left;
		logic [15:0] pulse_left;
		bit          pulse_on;
		bit          light;
		bit          wicket;
		logic [31:0] rev;
		logic [47:0] status_q[$];
		int          errors;

		function new();
			guard_cfg  = '0;
			pulse_cfg  = PULSE_TICKS_RST;
			hi         = 1'b1;
			gate       = GATE_UNKNOWN;
			motor      = MOTOR_STOP;
			pend       = MOTOR_STOP;
			guard_left = '0;
			pulse_left = '0;
			pulse_on   = 1'b0;
			light      = 1'b0;
			wicket     = 1'b0;
			rev        = '0;
			errors     = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				CFG_GUARD_TICKS: guard_cfg = val;
				CFG_PULSE_TICKS: pulse_cfg = val;
				CFG_ACTIVE_HIGH: hi = val[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return status_q.size();
		endfunction

		function void set_gate(gate_t g);
			if (gate != g) begin
				gate = g;
				rev++;
			end
		endfunction

		// Guard over: energize the pending direction
		function void energize();
			if (pend == MOTOR_OPEN) begin
				motor = MOTOR_OPEN;
				set_gate(GATE_OPENING);
			end else if (pend == MOTOR_CLOSE) begin
				motor = MOTOR_CLOSE;
				set_gate(GATE_CLOSING);
			end
			pend = MOTOR_STOP;
			guard_left = '0;
		endfunction

		function void drive(motor_t d);
			motor = MOTOR_STOP;
			pend = d;
			guard_left = guard_cfg;
			if (guard_left == 0)
				energize();
		endfunction

		function void halt_at(gate_t g);
			motor = MOTOR_STOP;
			pend = MOTOR_STOP;
			guard_left = '0;
			set_gate(g);
		endfunction

		function dir_t motion_sign(logic [1:0] v);
			if (v == 2'b01)
				return DIR_UP;
			if (v == 2'b00)
				return DIR_NONE;
			return DIR_DOWN;
		endfunction

		// Sensor group bits: active, in_motion, direction[1:0], just_settled, settled[1:0]
		function void motion(logic [6:0] s);
			if (s[1] && s[0]) begin
				if (motion_sign(s[3:2]) == DIR_UP)
					set_gate(GATE_OPENING);
				else if (motion_sign(s[3:2]) == DIR_DOWN)
					set_gate(GATE_CLOSING);
			end
		endfunction

		function void sensors(logic [6:0] u, logic [6:0] l);
			motion(u);
			motion(l);
			if (u[4] && motion_sign(u[6:5]) == DIR_UP) begin
				halt_at(GATE_OPEN);
			end else if (l[4] && motion_sign(l[6:5]) == DIR_DOWN) begin
				halt_at(GATE_CLOSED);
			end else begin
				if (u[4] && motion_sign(u[6:5]) == DIR_DOWN)
					set_gate(GATE_CLOSING);
				else if (l[4] && motion_sign(l[6:5]) == DIR_UP)
					set_gate(GATE_OPENING);
				// idle motor, unknown gate: infer from the single active sensor
				if (motor == MOTOR_STOP && gate == GATE_UNKNOWN) begin
					if (u[0] && !l[0])
						set_gate(GATE_OPEN);
					else if (l[0] && !u[0])
						set_gate(GATE_CLOSED);
				end
			end
		endfunction

		function void tick();
			if (pulse_on) begin
				if (pulse_left <= 1) begin
					pulse_on = 1'b0;
					pulse_left = '0;
					rev++;
				end else begin
					pulse_left--;
				end
			end
			if (pend != MOTOR_STOP) begin
				if (guard_left <= 1)
					energize();
				else
					guard_left--;
			end
		endfunction

		function void set_light(bit v);
			if (light != v) begin
				light = v;
				rev++;
			end
		endfunction

		function bit lvl(bit on);
			return on ? hi : !hi;
		endfunction

		// Accepted input item: advance state, queue the status it must produce
		function void note_item(logic [3:0] op, logic [15:0] data);
			case (op_t'(op))
				OP_TICK:         tick();
				OP_OPEN:         drive(MOTOR_OPEN);
				OP_CLOSE:        drive(MOTOR_CLOSE);
				OP_STOP: begin
					motor = MOTOR_STOP;
					pend = MOTOR_STOP;
					guard_left = '0;
					if (gate != GATE_OPEN && gate != GATE_CLOSED)
						set_gate(GATE_STOPPED);
				end
				OP_WICKET_PULSE: begin
					pulse_on = 1'b1;
					pulse_left = pulse_cfg;
					rev++;
				end
				OP_SET_LIGHT:    set_light(data[0]);
				OP_TOGGLE_LIGHT: set_light(!light);
				OP_SET_WICKET: begin
					if (wicket != data[0]) begin
						wicket = data[0];
						rev++;
					end
				end
				OP_SENSORS:      sensors(data[7:1], data[14:8]);
				default: ;
			endcase
			status_q.push_back({4'b0, rev, pulse_on, wicket, light, lvl(light), lvl(pulse_on),
				lvl(motor == MOTOR_CLOSE), lvl(motor == MOTOR_OPEN), motor, gate});
		endfunction

		function void cmp(string name, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
				errors++;
			end
		endfunction

		// Accepted status item: compare field by field with the oldest expectation
		function void check_status(logic [47:0] act);
			logic [47:0] e;
			if (status_q.size() == 0) begin
				$display("%0t: unexpected status item, expected none, got %h", $time, act);
				errors++;
				return;
			end
			e = status_q.pop_front();
			cmp("gate_state", 32'(e[2:0]), 32'(act[2:0]));
			cmp("motor_state", 32'(e[4:3]), 32'(act[4:3]));
			cmp("open_relay_level", 32'(e[5]), 32'(act[5]));
			cmp("close_relay_level", 32'(e[6]), 32'(act[6]));
			cmp("wicket_relay_level", 32'(e[7]), 32'(act[7]));
			cmp("light_relay_level", 32'(e[8]), 32'(act[8]));
			cmp("light_is_on", 32'(e[9]), 32'(act[9]));
			cmp("wicket_is_open", 32'(e[10]), 32'(act[10]));
			cmp("wicket_pulsing", 32'(e[11]), 32'(act[11]));
			cmp("revision", e[43:12], act[43:12]);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	gate_scoreboard sb = new();
	int  n_items = 0;
	int  idle_cycles = 0;
	bit  tx_calm = 1'b0;
	int  rx_hold = 0;
	int  rx_span = 0;
	bit  rx_calm = 1'b0;

	gate_motor_state_controller DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Gap length: mostly short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// One sensor group: active, in_motion, direction, just_settled, settled direction
	function automatic logic [6:0] grp(bit act, bit mv, logic [1:0] d, bit js, logic [1:0] sd);
		return {sd, js, d, mv, act};
	endfunction

	function automatic logic [15:0] sens(logic [6:0] up, logic [6:0] lo);
		return {1'b0, lo, up, 1'b0};
	endfunction

	// Result sink with random stalls, in calm and busy stretches
	always @(posedge clk) begin
		if (rx_span == 0) begin
			rx_span = $urandom_range(100, 400);
			rx_calm = ($urandom_range(0, 3) == 0);
		end
		rx_span--;
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else begin
			m_tready <= 1'b1;
			if (!rx_calm && $urandom_range(0, 4) == 0)
				rx_hold = gap_len();
		end
	end

	// Monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_item(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				sb.check_status(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Send one item; valid stays high unless a gap follows
	task automatic send(input logic [3:0] op, input logic [15:0] data);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= data & 16'h7fff;
		do @(posedge clk); while (!s_tready);
		if (op <= OP_SENSORS)
			n_items++;
		if (!tx_calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	// Hold the sender until every status item is back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input logic [15:0] guard, input logic [15:0] pulse,
		input logic hi);
		logic [1:0]  idx [3];
		logic [15:0] vals [3];
		idx = '{CFG_GUARD_TICKS, CFG_PULSE_TICKS, CFG_ACTIVE_HIGH};
		vals = '{guard, pulse, {15'd0, hi}};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.set_reg(idx[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Open or close, guard ticks, motion reports, then a settle at the limit or a random sensor report
	task automatic drive_run();
		bit         opening;
		int         nt;
		logic [1:0] dn;
		logic [6:0] mv;
		opening = 1'($urandom_range(0, 1));
		send(opening ? OP_OPEN : OP_CLOSE, 16'($urandom));
		if ($urandom_range(0, 5) == 0) begin
			opening = !opening;
			send(opening ? OP_OPEN : OP_CLOSE, 16'($urandom));
		end
		nt = (sb.guard_cfg > 6) ? $urandom_range(0, 8) : $urandom_range(0, sb.guard_cfg + 1);
		repeat (nt) send(OP_TICK, 16'($urandom));
		if ($urandom_range(0, 7) == 0)
			send(OP_STOP, 16'($urandom));
		repeat ($urandom_range(0, 3)) begin
			dn = {1'b1, 1'($urandom_range(0, 1))};
			mv = grp(1'b1, 1'b1, opening ? 2'b01 : dn, 1'b0, 2'b00);
			if ($urandom_range(0, 1))
				send(OP_SENSORS, sens(mv,
					grp(1'($urandom_range(0, 1)), 1'b0, 2'b00, 1'b0, 2'b00)));
			else
				send(OP_SENSORS, sens(
					grp(1'($urandom_range(0, 1)), 1'b0, 2'b00, 1'b0, 2'b00), mv));
		end
		dn = {1'b1, 1'($urandom_range(0, 1))};
		if ($urandom_range(0, 4) == 0)
			send(OP_SENSORS, 16'($urandom));
		else if (opening)
			send(OP_SENSORS, sens(grp(1'b1, 1'b0, 2'b00, 1'b1, 2'b01),
				grp(1'b0, 1'b0, 2'b00, 1'b0, 2'b00)));
		else
			send(OP_SENSORS, sens(grp(1'b0, 1'b0, 2'b00, 1'b0, 2'b00),
				grp(1'b1, 1'b0, 2'b00, 1'b1, dn)));
	endtask

	// Wicket pulse followed by a random number of ticks that can end it when short
	task automatic pulse_run();
		int nt;
		send(OP_WICKET_PULSE, 16'($urandom));
		nt = (sb.pulse_cfg > 6) ? $urandom_range(0, 8) : $urandom_range(0, sb.pulse_cfg + 2);
		repeat (nt) send(OP_TICK, 16'($urandom));
	endtask

	task automatic random_phase(input int count);
		int stop_at;
		int r;
		stop_at = n_items + count;
		while (n_items < stop_at) begin
			if ($urandom_range(0, 49) == 0)
				tx_calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 149) == 0)
				drain();
			r = $urandom_range(0, 99);
			if (r < 25)
				drive_run();
			else if (r < 35)
				pulse_run();
			else if (r < 55)
				send(OP_TICK, 16'($urandom));
			else if (r < 95)
				send(4'($urandom_range(OP_OPEN, OP_SENSORS)), 16'($urandom));
			else
				send(4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 16'($urandom));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Inference while a drive waits out its guard
		program_regs(16'd3, PULSE_TICKS_RST, 1'b1);
		send(OP_SPARE_LO, 16'h0000);
		send(OP_SENSORS, sens(grp(1'b1, 1'b0, 2'b00, 1'b0, 2'b00),
			grp(1'b1, 1'b0, 2'b00, 1'b0, 2'b00)));
		send(OP_OPEN, 16'h0000);
		if ($urandom_range(0, 1))
			send(OP_SENSORS, sens(grp(1'b1, 1'b0, 2'b00, 1'b0, 2'b00),
				grp(1'b0, 1'b0, 2'b00, 1'b0, 2'b00)));
		else
			send(OP_SENSORS, sens(grp(1'b0, 1'b0, 2'b00, 1'b0, 2'b00),
				grp(1'b1, 1'b0, 2'b00, 1'b0, 2'b00)));
		send(OP_TICK, 16'h0000);
		send(OP_STOP, 16'h0000);
		drain();

		// Zero guard, limits, stop, flags, odd sensor signs
		program_regs(16'd0, PULSE_TICKS_RST, 1'b1);
		send(OP_OPEN, 16'h0000);
		send(OP_SENSORS, sens(grp(1'b1, 1'b1, 2'b01, 1'b0, 2'b00),
			grp(1'b0, 1'b0, 2'b00, 1'b0, 2'b00)));
		send(OP_SENSORS, sens(grp(1'b1, 1'b0, 2'b00, 1'b1, 2'b01),
			grp(1'b0, 1'b0, 2'b00, 1'b0, 2'b00)));
		send(OP_CLOSE, 16'h0000);
		send(OP_SENSORS, sens(grp(1'b0, 1'b0, 2'b00, 1'b0, 2'b00),
			grp(1'b1, 1'b1, 2'b10, 1'b0, 2'b00)));
		send(OP_SENSORS, sens(grp(1'b0, 1'b0, 2'b00, 1'b0, 2'b00),
			grp(1'b1, 1'b0, 2'b00, 1'b1, 2'b11)));
		send(OP_STOP, 16'h0000);
		send(OP_OPEN, 16'h0000);
		send(OP_STOP, 16'h0000);
		send(OP_SENSORS, sens(grp(1'b0, 1'b0, 2'b00, 1'b1, 2'b10),
			grp(1'b0, 1'b0, 2'b00, 1'b0, 2'b00)));
		send(OP_SENSORS, sens(grp(1'b0, 1'b0, 2'b00, 1'b0, 2'b00),
			grp(1'b0, 1'b0, 2'b00, 1'b1, 2'b01)));
		send(OP_WICKET_PULSE, 16'h0000);
		send(OP_TICK, 16'h0000);
		send(OP_SET_LIGHT, 16'h0001);
		send(OP_SET_LIGHT, 16'h0001);
		send(OP_TOGGLE_LIGHT, 16'h0000);
		send(OP_SET_WICKET, 16'h0001);
		send(OP_SET_WICKET, 16'h0000);
		send(OP_SENSORS, 16'h7fff);
		send(OP_SPARE_HI, 16'h7fff);
		send(OP_SENSORS, 16'h0000);

		// Random phases over several register settings
		for (int p = 0; p < 5; p++) begin
			drain();
			case (p)
				0: program_regs(16'd1, 16'd0, 1'b0);
				1: program_regs(16'd3, 16'd2, 1'b1);
				2: program_regs(16'hffff, 16'hffff, 1'b0);
				3: program_regs(16'd2, 16'd1, 1'b1);
				default: program_regs(16'd0, 16'd7, 1'b0);
			endcase
			random_phase(PHASE_ITEMS);
		end

		// Let the last results come back
		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
